>>> rtl/depth_to_color_registration_core_assert.svh
// Assertion macros for the registration core
`ifndef DEPTH_TO_COLOR_REGISTRATION_CORE_ASSERT_SVH
`define DEPTH_TO_COLOR_REGISTRATION_CORE_ASSERT_SVH
// implication checked outside reset
`define DTCR_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("registration core assertion failed");
// implication checked on every edge, reset included
`define DTCR_ASSERT_ALWAYS(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |-> (b)) \
        else $error("registration core assertion failed");
`endif

>>> rtl/dtcr_pkg.sv
// Shared types and constants of the registration core
`timescale 1ns / 1ps
package dtcr_pkg;
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;
    localparam int CFG_W   = 14;
    localparam int CFG_N   = 8;
    localparam int ADDR_W  = 3;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int DEPTH_W = 16;
    localparam int MASK_W  = 8;
    localparam int NUMC_W  = 47;
    localparam int DENC_W  = 34;
    localparam int NUMR_W  = 31;
    localparam int DENR_W  = 18;
    localparam int FRONT_LAT = 3;

    typedef enum logic [ADDR_W-1:0] {
        REG_DEPTH_FOCAL_X  = 3'd0,
        REG_DEPTH_CENTER_X = 3'd1,
        REG_DEPTH_FOCAL_Y  = 3'd2,
        REG_DEPTH_CENTER_Y = 3'd3,
        REG_COLOR_FOCAL_X  = 3'd4,
        REG_COLOR_CENTER_X = 3'd5,
        REG_COLOR_FOCAL_Y  = 3'd6,
        REG_COLOR_CENTER_Y = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_FOCAL    = 14'd8400;
    localparam logic [CFG_W-1:0] RST_CENTER_X = 14'd5112;
    localparam logic [CFG_W-1:0] RST_CENTER_Y = 14'd3832;

    typedef struct packed {
        logic [CFG_W-1:0] fxd;
        logic [CFG_W-1:0] cxd;
        logic [CFG_W-1:0] fyd;
        logic [CFG_W-1:0] cyd;
        logic [CFG_W-1:0] fxr;
        logic [CFG_W-1:0] cxr;
        logic [CFG_W-1:0] fyr;
        logic [CFG_W-1:0] cyr;
    } t_cfg;

    typedef struct packed {
        logic              ok;
        logic [NUMC_W-1:0] numc;
        logic [DENC_W-1:0] denc;
        logic [NUMR_W-1:0] numr;
        logic [DENR_W-1:0] denr;
    } t_front;
endpackage

>>> rtl/dtcr_front.sv
// Projection arithmetic: numerators and denominators, three stages
`timescale 1ns / 1ps
module dtcr_front import dtcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_col,
    input  logic [DEPTH_W-1:0] i_depth,
    output t_front             o_front
);
    // stage 1
    logic signed [15:0] n_dx, n_dy;
    logic signed [30:0] r_p1, r_ry;
    logic [27:0]        r_p2, r_ff, r_rc;
    logic [29:0]        r_dd;
    logic [DENR_W-1:0]  r_denr1, r_denr2;
    logic [DEPTH_W-1:0] r_dep1;
    logic               r_ok1, r_ok2;
    // stage 2
    logic signed [47:0] r_a;
    logic [43:0]        r_b;
    logic [32:0]        r_c;
    logic [DENC_W-1:0]  r_denc2;
    logic signed [31:0] r_numr2;
    // stage 3
    logic signed [47:0] n_numc;
    t_front             r_out;

    assign n_dx = $signed({2'b0, i_col, 4'b0}) - $signed({2'b0, i_cfg.cxd});
    assign n_dy = $signed({3'b0, i_row, 4'b0}) - $signed({2'b0, i_cfg.cyd});
    assign n_numc = r_a + $signed({4'b0, r_b}) + $signed({15'b0, r_c});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= 31'(n_dx) * 31'($signed({1'b0, i_cfg.fxr}));
            r_ry    <= 31'(n_dy) * 31'($signed({1'b0, i_cfg.fyr}));
            r_p2    <= 28'(i_cfg.cxr) * 28'(i_cfg.fxd);
            r_ff    <= 28'(i_cfg.fxr) * 28'(i_cfg.fxd);
            r_rc    <= 28'(i_cfg.cyr) * 28'(i_cfg.fyd);
            r_dd    <= 30'(i_cfg.fxd) * 30'(i_depth);
            r_denr1 <= {i_cfg.fyd, 4'b0};
            r_dep1  <= i_depth;
            r_ok1   <= (i_depth != '0) && (i_cfg.fxd != '0) && (i_cfg.fyd != '0);

            r_a     <= 48'(r_p1) * 48'($signed({1'b0, r_dep1}));
            r_b     <= 44'(r_p2) * 44'(r_dep1);
            // 25 = 16 + 8 + 1
            r_c     <= 33'({r_ff, 4'b0}) + 33'({r_ff, 3'b0}) + 33'(r_ff);
            r_denc2 <= {r_dd, 4'b0};
            r_numr2 <= 32'(r_ry) + $signed({4'b0, r_rc});
            r_denr2 <= r_denr1;
            r_ok2   <= r_ok1;

            r_out.ok   <= r_ok2 && !n_numc[47] && !r_numr2[31];
            r_out.numc <= n_numc[NUMC_W-1:0];
            r_out.denc <= r_denc2;
            r_out.numr <= r_numr2[NUMR_W-1:0];
            r_out.denr <= r_denr2;
        end
    end

    assign o_front = r_out;
endmodule

>>> rtl/dtcr_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module dtcr_div import dtcr_pkg::*; #(
    parameter int NUM_W = NUMC_W,
    parameter int DEN_W = DENC_W,
    parameter int QB    = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_ok,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_ok,
    output logic [QB-1:0]    o_quo
);
    localparam int W = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

    logic [NUM_W-1:0] r_rem [QB];
    logic [DEN_W-1:0] r_den [QB];
    logic [QB-1:0]    r_q   [QB+1];
    logic             r_ok  [QB+1];

    // entry stage: quotient must fit QB bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ok[0]  <= i_ok && (W'(i_num) < W'({i_den, {QB{1'b0}}}));
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [W-1:0] n_sh;
        logic         n_ge;
        assign n_sh = W'(r_den[k-1]) << (QB - k);
        assign n_ge = W'(r_rem[k-1]) >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]  <= QB'({r_q[k-1], n_ge});
                r_ok[k] <= r_ok[k-1];
            end
        end
        if (k < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_ge ? NUM_W'(W'(r_rem[k-1]) - n_sh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_ok  = r_ok[QB];
    assign o_quo = r_q[QB];
endmodule

>>> rtl/depth_to_color_registration_core.sv
// Top level: depth pixel to color frame registration pipeline
//
// Usage: one depth pixel per transaction on the input channel (i_valid /
// o_ready with row, column, depth and mask). Each input transaction yields
// exactly one output transaction (o_valid / i_ready) holding write_valid,
// the target row and column in the color frame, and the unchanged depth and
// mask. With write_valid low all other output fields are zero.
// Pipeline: 3 arithmetic stages, QB + 1 divider stages and one output
// register, QB = clog2(max(FRAME_WIDTH, FRAME_HEIGHT)). Throughput: one
// pixel per cycle unless the receiver stalls; the two divisions run in
// parallel bit-per-stage pipelines. The user must write the intrinsics
// through the plain write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata)
// only while no pixel is in flight; the core does not enforce this.
// Reset (synchronous, active low) empties the pipeline and loads the
// default intrinsics. When the receiver holds i_ready low with a result
// waiting, the whole pipeline freezes and o_ready drops; nothing is lost.
`timescale 1ns / 1ps
module depth_to_color_registration_core import dtcr_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ROW_W-1:0]   i_pixel_row,
    input  logic [COL_W-1:0]   i_pixel_col,
    input  logic [DEPTH_W-1:0] i_depth_mm,
    input  logic [MASK_W-1:0]  i_mask_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_write_valid,
    output logic [ROW_W-1:0]   o_target_row,
    output logic [COL_W-1:0]   o_target_col,
    output logic [DEPTH_W-1:0] o_out_depth,
    output logic [MASK_W-1:0]  o_out_mask
);
`include "depth_to_color_registration_core_assert.svh"

    localparam int MAXDIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int QB     = $clog2(MAXDIM);
    localparam int DLY    = FRONT_LAT + QB + 1;

    t_cfg               r_cfg;
    t_front             w_front;
    logic               w_en;
    logic               w_okc, w_okr;
    logic [QB-1:0]      w_qc, w_qr;
    logic               n_wv;
    logic               r_v   [DLY];
    logic [DEPTH_W-1:0] r_dep [DLY];
    logic [MASK_W-1:0]  r_msk [DLY];
    logic               r_ov, r_wv;
    logic [ROW_W-1:0]   r_trow;
    logic [COL_W-1:0]   r_tcol;
    logic [DEPTH_W-1:0] r_odep;
    logic [MASK_W-1:0]  r_omsk;

    // global advance: the output register is free or being emptied
    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    // intrinsics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fxd <= RST_FOCAL;
            r_cfg.cxd <= RST_CENTER_X;
            r_cfg.fyd <= RST_FOCAL;
            r_cfg.cyd <= RST_CENTER_Y;
            r_cfg.fxr <= RST_FOCAL;
            r_cfg.cxr <= RST_CENTER_X;
            r_cfg.fyr <= RST_FOCAL;
            r_cfg.cyr <= RST_CENTER_Y;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_DEPTH_FOCAL_X:  r_cfg.fxd <= i_cfg_wdata;
                REG_DEPTH_CENTER_X: r_cfg.cxd <= i_cfg_wdata;
                REG_DEPTH_FOCAL_Y:  r_cfg.fyd <= i_cfg_wdata;
                REG_DEPTH_CENTER_Y: r_cfg.cyd <= i_cfg_wdata;
                REG_COLOR_FOCAL_X:  r_cfg.fxr <= i_cfg_wdata;
                REG_COLOR_CENTER_X: r_cfg.cxr <= i_cfg_wdata;
                REG_COLOR_FOCAL_Y:  r_cfg.fyr <= i_cfg_wdata;
                REG_COLOR_CENTER_Y: r_cfg.cyr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dtcr_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_row   (i_pixel_row),
        .i_col   (i_pixel_col),
        .i_depth (i_depth_mm),
        .o_front (w_front)
    );

    dtcr_div #(.NUM_W(NUMC_W), .DEN_W(DENC_W), .QB(QB)) u_div_col (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ok  (w_front.ok),
        .i_num (w_front.numc),
        .i_den (w_front.denc),
        .o_ok  (w_okc),
        .o_quo (w_qc)
    );

    dtcr_div #(.NUM_W(NUMR_W), .DEN_W(DENR_W), .QB(QB)) u_div_row (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ok  (1'b1),
        .i_num (w_front.numr),
        .i_den (w_front.denr),
        .o_ok  (w_okr),
        .o_quo (w_qr)
    );

    // valid bits and pass-through payload, aligned with the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DLY; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dep[0] <= i_depth_mm;
            r_msk[0] <= i_mask_value;
            for (int k = 1; k < DLY; k++) begin
                r_dep[k] <= r_dep[k-1];
                r_msk[k] <= r_msk[k-1];
            end
        end
    end

    // final range check against the frame
    assign n_wv = w_okc && w_okr
               && ({1'b0, w_qc} < (QB+1)'(FRAME_WIDTH))
               && ({1'b0, w_qr} < (QB+1)'(FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_v[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wv   <= n_wv;
            r_trow <= n_wv ? ROW_W'(w_qr) : '0;
            r_tcol <= n_wv ? COL_W'(w_qc) : '0;
            r_odep <= n_wv ? r_dep[DLY-1] : '0;
            r_omsk <= n_wv ? r_msk[DLY-1] : '0;
        end
    end

    assign o_valid       = r_ov;
    assign o_write_valid = r_wv;
    assign o_target_row  = r_trow;
    assign o_target_col  = r_tcol;
    assign o_out_depth   = r_odep;
    assign o_out_mask    = r_omsk;

    `DTCR_ASSERT_ALWAYS(a_rst_empty, i_clk, $past(!i_rst_n), !o_valid)
    `DTCR_ASSERT_IMPL(a_inval_zero, i_clk, i_rst_n, o_valid && !o_write_valid, (o_target_row == '0) && (o_target_col == '0) && (o_out_depth == '0) && (o_out_mask == '0))
    `DTCR_ASSERT_IMPL(a_wr_depth, i_clk, i_rst_n, o_valid && o_write_valid, o_out_depth != '0)
    `DTCR_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
endmodule

>>> verif/depth_to_color_registration_core_tb.sv
// Self-checking testbench for the depth-to-color registration core
`timescale 1ns / 1ps
module depth_to_color_registration_core_tb;
    import dtcr_pkg::*;

    // Cycles with no transaction on either channel before the run is abandoned.
    // The longest legal quiet stretch is the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    // Pipeline depth from the top-level header plus margin.
    localparam int SETTLE_CYCLES  = 20;

    // One expected output transaction
    typedef struct {
        logic               write_valid;
        logic [ROW_W-1:0]   target_row;
        logic [COL_W-1:0]   target_col;
        logic [DEPTH_W-1:0] out_depth;
        logic [MASK_W-1:0]  out_mask;
    } t_reg_write;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic [ROW_W-1:0]   i_pixel_row;
    logic [COL_W-1:0]   i_pixel_col;
    logic [DEPTH_W-1:0] i_depth_mm;
    logic [MASK_W-1:0]  i_mask_value;
    logic               o_valid;
    logic               i_ready;
    logic               o_write_valid;
    logic [ROW_W-1:0]   o_target_row;
    logic [COL_W-1:0]   o_target_col;
    logic [DEPTH_W-1:0] o_out_depth;
    logic [MASK_W-1:0]  o_out_mask;

    // Testbench copy of the intrinsics register file
    logic [CFG_W-1:0] intrinsics[CFG_N];

    t_reg_write pending_writes[$];
    int         mismatch_count;
    int         quiet_cycles;
    int         hold_cnt;
    bit         long_hold_pending;
    bit         tx_idle_en;
    bit         rx_idle_en;

    depth_to_color_registration_core dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    //------------------------------------------------------------------
    // Predictor: exact floor of the rational projection, all integers.
    // Column and row are each brought over one common denominator so no
    // intermediate rounding happens.
    //------------------------------------------------------------------
    function automatic t_reg_write project_pixel(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col,
                                                 logic [DEPTH_W-1:0] depth,
                                                 logic [MASK_W-1:0] mask);
        t_reg_write res;
        longint fxd, cxd, fyd, cyd, fxr, cxr, fyr, cyr;
        longint dx, dy, num, den, tcol, trow;
        bit ok;
        fxd = intrinsics[REG_DEPTH_FOCAL_X];
        cxd = intrinsics[REG_DEPTH_CENTER_X];
        fyd = intrinsics[REG_DEPTH_FOCAL_Y];
        cyd = intrinsics[REG_DEPTH_CENTER_Y];
        fxr = intrinsics[REG_COLOR_FOCAL_X];
        cxr = intrinsics[REG_COLOR_CENTER_X];
        fyr = intrinsics[REG_COLOR_FOCAL_Y];
        cyr = intrinsics[REG_COLOR_CENTER_Y];
        tcol = 0;
        trow = 0;
        ok = (depth != 0) && (fxd != 0) && (fyd != 0);
        if (ok) begin
            // baseline shift of 25 mm along X
            dx  = longint'(col) * 16 - cxd;
            num = dx * fxr * longint'(depth) + 25 * fxr * fxd + cxr * fxd * longint'(depth);
            den = 16 * fxd * longint'(depth);
            if (num < 0) ok = 0;
            else begin
                tcol = num / den;
                ok = tcol < 640;
            end
        end
        if (ok) begin
            dy  = longint'(row) * 16 - cyd;
            num = dy * fyr + cyr * fyd;
            den = 16 * fyd;
            if (num < 0) ok = 0;
            else begin
                trow = num / den;
                ok = trow < 480;
            end
        end
        res.write_valid = ok;
        res.target_row  = ok ? trow[ROW_W-1:0] : '0;
        res.target_col  = ok ? tcol[COL_W-1:0] : '0;
        res.out_depth   = ok ? depth : '0;
        res.out_mask    = ok ? mask : '0;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    //------------------------------------------------------------------
    // Receiver: checks each accepted result against the oldest expectation
    // and drives i_ready with random stall bursts and the long hold-off.
    // Reads at the edge see pre-edge values, so sampling is race free.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reg_write exp_w;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    exp_w = pending_writes.pop_front();
                    if (o_write_valid !== exp_w.write_valid)
                        report_mismatch($sformatf("write_valid %0b exp %0b",
                                        o_write_valid, exp_w.write_valid));
                    if (o_target_row !== exp_w.target_row)
                        report_mismatch($sformatf("target_row %0d exp %0d",
                                        o_target_row, exp_w.target_row));
                    if (o_target_col !== exp_w.target_col)
                        report_mismatch($sformatf("target_col %0d exp %0d",
                                        o_target_col, exp_w.target_col));
                    if (o_out_depth !== exp_w.out_depth)
                        report_mismatch($sformatf("out_depth %0d exp %0d",
                                        o_out_depth, exp_w.out_depth));
                    if (o_out_mask !== exp_w.out_mask)
                        report_mismatch($sformatf("out_mask %0d exp %0d",
                                        o_out_mask, exp_w.out_mask));
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (long_hold_pending) begin
                long_hold_pending = 0;
                hold_cnt = LONG_HOLD - 1;
                i_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(0, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: no transaction on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // Sender helpers; all called at a rising edge and return at one
    //------------------------------------------------------------------
    task automatic send_pixel(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                              logic [DEPTH_W-1:0] depth, logic [MASK_W-1:0] mask);
        i_valid      <= 1'b1;
        i_pixel_row  <= row;
        i_pixel_col  <= col;
        i_depth_mm   <= depth;
        i_mask_value <= mask;
        do @(posedge i_clk); while (!o_ready);
        pending_writes.push_back(project_pixel(row, col, depth, mask));
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_intrinsic(t_reg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        intrinsics[idx] = value;
    endtask

    task automatic load_camera(logic [CFG_W-1:0] fxd, logic [CFG_W-1:0] cxd,
                               logic [CFG_W-1:0] fyd, logic [CFG_W-1:0] cyd,
                               logic [CFG_W-1:0] fxr, logic [CFG_W-1:0] cxr,
                               logic [CFG_W-1:0] fyr, logic [CFG_W-1:0] cyr);
        drain_pipeline();
        write_intrinsic(REG_DEPTH_FOCAL_X, fxd);
        write_intrinsic(REG_DEPTH_CENTER_X, cxd);
        write_intrinsic(REG_DEPTH_FOCAL_Y, fyd);
        write_intrinsic(REG_DEPTH_CENTER_Y, cyd);
        write_intrinsic(REG_COLOR_FOCAL_X, fxr);
        write_intrinsic(REG_COLOR_CENTER_X, cxr);
        write_intrinsic(REG_COLOR_FOCAL_Y, fyr);
        write_intrinsic(REG_COLOR_CENTER_Y, cyr);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly plausible in-frame pixels; some noise over the full field widths
    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        if ($urandom_range(0, 9) == 0) begin
            depth = ($urandom_range(0, 3) == 0) ? '0 : DEPTH_W'($urandom);
            send_pixel(ROW_W'($urandom), COL_W'($urandom), depth, MASK_W'($urandom));
        end else begin
            depth = $urandom_range(0, 3) == 0 ? DEPTH_W'($urandom_range(1, 65535))
                                               : DEPTH_W'($urandom_range(300, 8000));
            send_pixel(ROW_W'($urandom_range(0, 479)), COL_W'($urandom_range(0, 639)),
                       depth, MASK_W'($urandom));
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_reset_defaults();
        // corners of the input fields under the reset intrinsics
        send_pixel(9'd0, 10'd0, 16'd1000, 8'h00);
        send_pixel(9'd479, 10'd639, 16'd1000, 8'hFF);
        send_pixel(9'd511, 10'd1023, 16'hFFFF, 8'hA5);
        send_pixel(9'd240, 10'd320, 16'd0, 8'hFF);     // no depth reading
        send_pixel(9'd240, 10'd320, 16'd1, 8'h5A);     // tiny depth, huge shift
        send_pixel(9'd240, 10'd320, 16'hFFFF, 8'h01);
        send_pixel(9'd240, 10'd620, 16'd400, 8'h80);   // shifted past right edge
        send_pixel(9'd0, 10'd0, 16'd26, 8'h7F);
        drain_pipeline();
    endtask

    task automatic test_intrinsic_extremes();
        // smallest focal lengths, centers at zero
        load_camera(14'd16, 14'd0, 14'd16, 14'd0, 14'd16, 14'd0, 14'd16, 14'd0);
        send_pixel(9'd0, 10'd0, 16'd1, 8'h11);
        send_pixel(9'd100, 10'd200, 16'd5000, 8'h22);
        send_pixel(9'd479, 10'd639, 16'hFFFF, 8'h33);
        // largest values everywhere: pushes the wide products to their limit
        load_camera(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
                    14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_pixel(9'd0, 10'd0, 16'hFFFF, 8'h44);
        send_pixel(9'd511, 10'd1023, 16'hFFFF, 8'h55);
        send_pixel(9'd511, 10'd1023, 16'd1, 8'h66);
        // zero depth focal length in x, then in y
        load_camera(14'd0, 14'd5112, 14'd8400, 14'd3832, 14'd8400, 14'd5112, 14'd8400, 14'd3832);
        send_pixel(9'd240, 10'd320, 16'd1000, 8'h77);
        load_camera(14'd8400, 14'd5112, 14'd0, 14'd3832, 14'd8400, 14'd5112, 14'd8400, 14'd3832);
        send_pixel(9'd240, 10'd320, 16'd1000, 8'h88);
        drain_pipeline();
    endtask

    task automatic test_random_cameras();
        int batch;
        for (batch = 0; batch < 16; batch++) begin
            if (batch % 4 == 3)
                load_camera(CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom), CFG_W'($urandom));
            else
                load_camera(CFG_W'($urandom_range(4000, 16383)),
                            CFG_W'($urandom_range(3000, 7000)),
                            CFG_W'($urandom_range(4000, 16383)),
                            CFG_W'($urandom_range(2000, 5000)),
                            CFG_W'($urandom_range(4000, 16383)),
                            CFG_W'($urandom_range(3000, 7000)),
                            CFG_W'($urandom_range(4000, 16383)),
                            CFG_W'($urandom_range(2000, 5000)));
            // some batches run with no idling at all
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            repeat (100) send_random_pixel();
        end
        drain_pipeline();
    endtask

    task automatic test_output_backpressure();
        // receiver goes quiet while the sender keeps offering: the pipe fills
        tx_idle_en = 0;
        long_hold_pending = 1;
        repeat (60) send_random_pixel();
        // sender pauses here until every result has been drained
        drain_pipeline();
        tx_idle_en = 1;
        rx_idle_en = 1;
        repeat (40) send_random_pixel();
        drain_pipeline();
    endtask

    task automatic test_full_rate_tail();
        load_camera(14'd8400, 14'd5112, 14'd8400, 14'd3832, 14'd8400, 14'd5112, 14'd8400, 14'd3832);
        tx_idle_en = 0;
        rx_idle_en = 0;
        repeat (100) send_random_pixel();
        drain_pipeline();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_pixel_row  = '0;
        i_pixel_col  = '0;
        i_depth_mm   = '0;
        i_mask_value = '0;
        mismatch_count    = 0;
        long_hold_pending = 0;
        tx_idle_en        = 1;
        rx_idle_en        = 1;
        intrinsics[REG_DEPTH_FOCAL_X]  = RST_FOCAL;
        intrinsics[REG_DEPTH_CENTER_X] = RST_CENTER_X;
        intrinsics[REG_DEPTH_FOCAL_Y]  = RST_FOCAL;
        intrinsics[REG_DEPTH_CENTER_Y] = RST_CENTER_Y;
        intrinsics[REG_COLOR_FOCAL_X]  = RST_FOCAL;
        intrinsics[REG_COLOR_CENTER_X] = RST_CENTER_X;
        intrinsics[REG_COLOR_FOCAL_Y]  = RST_FOCAL;
        intrinsics[REG_COLOR_CENTER_Y] = RST_CENTER_Y;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_intrinsic_extremes();
        test_random_cameras();
        test_output_backpressure();
        test_full_rate_tail();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/dtcr_pkg.sv
rtl/dtcr_front.sv
rtl/dtcr_div.sv
rtl/depth_to_color_registration_core.sv
verif/depth_to_color_registration_core_tb.sv
